FILE: rtl/ipm_pkg.sv
`timescale 1ns / 1ps

package ipm_pkg;

    localparam int NUM_CAMS_DEF = 4;
    localparam int BEV_SIZE_DEF = 1024;
    localparam int WORDS        = 19;

    // calibration word slots
    localparam int IDX_T0 = 9;
    localparam int IDX_XI = 12;
    localparam int IDX_FX = 13;
    localparam int IDX_FY = 14;
    localparam int IDX_CX = 15;
    localparam int IDX_CY = 16;
    localparam int IDX_W  = 17;
    localparam int IDX_H  = 18;

    localparam logic [0:0]  OP_LOAD  = 1'b0;
    localparam logic [0:0]  OP_MAP   = 1'b1;
    localparam logic [1:0]  ST_INSIDE  = 2'd0;
    localparam logic [1:0]  ST_BEHIND  = 2'd1;
    localparam logic [1:0]  ST_OUTSIDE = 2'd2;
    localparam logic [20:0] GS_RESET = 21'd1311;

    // root bits per sqrt stage, quotient bits per divider stage
    localparam int SQ_STEPS = 2;
    localparam int SQ_STG   = 32 / SQ_STEPS;
    localparam int DV_STEPS = 2;
    localparam int DV_STG   = 48 / DV_STEPS;

    typedef struct packed {
        logic [0:0]         op;
        logic [2:0]         cam_sel;
        logic [4:0]         coef_index;
        logic signed [31:0] coef_value;
        logic [11:0]        bev_u;
        logic [11:0]        bev_v;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  cam_id;
        logic [1:0]  status;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic        last;
    } out_beat_t;

    typedef struct packed {
        logic [2:0]              cam;
        logic                    last;
        logic signed [31:0]      gx;
        logic signed [31:0]      gy;
        logic [WORDS-1:0][31:0]  row;
    } issue_t;

    typedef struct packed {
        logic [2:0]         cam;
        logic               last;
        logic signed [31:0] xi;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } cal_t;

    typedef struct packed {
        cal_t               cal;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] zs;
    } tail_t;

    typedef struct packed {
        cal_t cal;
        logic behind;
        logic x_neg;
        logic y_neg;
    } div_tail_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            return 32'sh80000000;
        return 32'(x);
    endfunction

    // Q16.16 product back to Q16.16, half up
    function automatic logic signed [65:0] rnd_q16(input logic signed [65:0] p);
        return (p + 66'sd32768) >>> 16;
    endfunction

endpackage

FILE: rtl/ipm_unified_camera_remap.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Beat
// in      | input     | in_valid/in_stall  | ipm_pkg::in_beat_t (load or map)
// out     | output    | out_valid/out_stall| ipm_pkg::out_beat_t (one per camera)
// cfg     | input     | cfg_we             | cfg_wdata, ground_scale (unsigned Q5.16)
//
// A map pixel is issued as NUM_CAMS camera projections, one per cycle into the
// pipeline unless the output is stalled, which is the rate limit. The first
// result passes the issue register, 4 point stages, 16 sqrt stages, 2 denominator
// stages, 24 divider stages and 4 output stages. Reset clears valid bits and the
// sequencer and sets ground_scale to 1311; the calibration table holds no reset
// value. A stalled output freezes every stage from the issue register on.

module ipm_unified_camera_remap #(
    parameter int NUM_CAMS = ipm_pkg::NUM_CAMS_DEF,
    parameter int BEV_SIZE = ipm_pkg::BEV_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ipm_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_stall,
    output ipm_pkg::out_beat_t out_beat,
    input  logic               cfg_we,
    input  logic [20:0]        cfg_wdata
);
    // whole pipeline advances together unless the output beat is held
    logic en;
    logic out_valid_reg;
    ipm_pkg::out_beat_t out_beat_reg;

    assign en = !out_valid_reg || !out_stall;

    // issue stage: calibration row read and ground point
    logic            s1_valid;
    ipm_pkg::issue_t s1;

    ipm_seq #(
        .NUM_CAMS (NUM_CAMS),
        .BEV_SIZE (BEV_SIZE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .iss_valid (s1_valid),
        .iss       (s1)
    );

    // stage 2: rotation products
    logic               s2_valid_reg;
    logic signed [63:0] s2_p_reg [6];
    logic signed [31:0] s2_t_reg [3];
    ipm_pkg::cal_t      s2_cal_reg;

    // stage 3: camera-frame point
    logic               s3_valid_reg;
    logic signed [31:0] s3_x_reg [3];
    ipm_pkg::cal_t      s3_cal_reg;

    // stage 4: squares
    logic               s4_valid_reg;
    logic signed [63:0] s4_sq_reg [3];
    ipm_pkg::tail_t     s4_tail_reg;

    // stage 5: sum of squares
    logic               s5_valid_reg;
    logic [63:0]        s5_sum_reg;
    ipm_pkg::tail_t     s5_tail_reg;

    logic               sq_valid;
    logic [31:0]        sq_root;
    ipm_pkg::tail_t     sq_tail;

    // stage P1: xi * d
    logic               p1_valid_reg;
    logic signed [64:0] p1_m_reg;
    ipm_pkg::tail_t     p1_tail_reg;

    // stage P2: denominator and divider operands
    logic               p2_valid_reg;
    logic [47:0]        p2_a_reg, p2_b_reg;
    logic [30:0]        p2_d_reg;
    ipm_pkg::div_tail_t p2_tail_reg;

    logic               dv_valid;
    logic [47:0]        dv_qa, dv_qb;
    ipm_pkg::div_tail_t dv_tail;

    // stage Q1: signed normalized coordinates
    logic               q1_valid_reg;
    logic signed [31:0] q1_xn_reg, q1_yn_reg;
    ipm_pkg::div_tail_t q1_tail_reg;

    // stage Q2: focal products
    logic               q2_valid_reg;
    logic signed [63:0] q2_px_reg, q2_py_reg;
    ipm_pkg::div_tail_t q2_tail_reg;

    // stage Q3: principal point and rounding
    logic               q3_valid_reg;
    logic signed [33:0] q3_px_reg, q3_py_reg;
    ipm_pkg::div_tail_t q3_tail_reg;

    // Q32.32 to integer, halves away from zero
    function automatic logic signed [33:0] rnd_q32(input logic signed [64:0] v);
        logic signed [65:0] a;
        if (!v[64])
        begin
            a = 66'(v) + 66'sd2147483648;
            return 34'(a >>> 32);
        end
        a = 66'sd2147483648 - 66'(v);
        return -(34'(a >>> 32));
    endfunction

    logic signed [63:0] p_next [6];
    logic signed [31:0] x_next [3];
    logic signed [31:0] den;
    logic signed [31:0] ax, ay;
    logic               in_image;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_next[2*k]   = $signed(s1.row[3*k]) * s1.gx;
            p_next[2*k+1] = $signed(s1.row[3*k+1]) * s1.gy;
            x_next[k] = ipm_pkg::sat32(
                66'(ipm_pkg::sat32(ipm_pkg::rnd_q16(66'(s2_p_reg[2*k]))))
                + 66'(ipm_pkg::sat32(ipm_pkg::rnd_q16(66'(s2_p_reg[2*k+1]))))
                + 66'(s2_t_reg[k]));
        end
    end

    assign den = ipm_pkg::sat32(66'(p1_tail_reg.zs) + ipm_pkg::rnd_q16(66'(p1_m_reg)));
    assign ax  = p1_tail_reg.xs[31] ? -p1_tail_reg.xs : p1_tail_reg.xs;
    assign ay  = p1_tail_reg.ys[31] ? -p1_tail_reg.ys : p1_tail_reg.ys;

    assign in_image = (q3_px_reg >= 34'sd0) && (q3_px_reg < 34'(q3_tail_reg.cal.w))
                   && (q3_px_reg <= 34'sd4095)
                   && (q3_py_reg >= 34'sd0) && (q3_py_reg < 34'(q3_tail_reg.cal.h))
                   && (q3_py_reg <= 34'sd4095);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            q1_valid_reg  <= 1'b0;
            q2_valid_reg  <= 1'b0;
            q3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= s1_valid;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            p1_valid_reg  <= sq_valid;
            p2_valid_reg  <= p1_valid_reg;
            q1_valid_reg  <= dv_valid;
            q2_valid_reg  <= q1_valid_reg;
            q3_valid_reg  <= q2_valid_reg;
            out_valid_reg <= q3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
                s2_p_reg[k] <= p_next[k];
            for (int k = 0; k < 3; k++)
                s2_t_reg[k] <= $signed(s1.row[ipm_pkg::IDX_T0+k]);
            s2_cal_reg.cam  <= s1.cam;
            s2_cal_reg.last <= s1.last;
            s2_cal_reg.xi   <= $signed(s1.row[ipm_pkg::IDX_XI]);
            s2_cal_reg.fx   <= $signed(s1.row[ipm_pkg::IDX_FX]);
            s2_cal_reg.fy   <= $signed(s1.row[ipm_pkg::IDX_FY]);
            s2_cal_reg.cx   <= $signed(s1.row[ipm_pkg::IDX_CX]);
            s2_cal_reg.cy   <= $signed(s1.row[ipm_pkg::IDX_CY]);
            s2_cal_reg.w    <= $signed(s1.row[ipm_pkg::IDX_W][31:16]);
            s2_cal_reg.h    <= $signed(s1.row[ipm_pkg::IDX_H][31:16]);

            for (int k = 0; k < 3; k++)
                s3_x_reg[k] <= x_next[k];
            s3_cal_reg <= s2_cal_reg;

            for (int k = 0; k < 3; k++)
                s4_sq_reg[k] <= s3_x_reg[k] * s3_x_reg[k];
            s4_tail_reg.cal <= s3_cal_reg;
            s4_tail_reg.xs  <= s3_x_reg[0];
            s4_tail_reg.ys  <= s3_x_reg[1];
            s4_tail_reg.zs  <= s3_x_reg[2];

            s5_sum_reg  <= $unsigned(s4_sq_reg[0]) + $unsigned(s4_sq_reg[1])
                         + $unsigned(s4_sq_reg[2]);
            s5_tail_reg <= s4_tail_reg;

            p1_m_reg    <= sq_tail.cal.xi * $signed({1'b0, sq_root});
            p1_tail_reg <= sq_tail;

            // den <= 0 means behind the camera; divider output is then ignored
            p2_a_reg <= {ax, 16'h0000};
            p2_b_reg <= {ay, 16'h0000};
            p2_d_reg <= den[30:0];
            p2_tail_reg.cal    <= p1_tail_reg.cal;
            p2_tail_reg.behind <= den[31] || (den == 32'sd0);
            p2_tail_reg.x_neg  <= p1_tail_reg.xs[31];
            p2_tail_reg.y_neg  <= p1_tail_reg.ys[31];

            q1_xn_reg <= ipm_pkg::sat32(dv_tail.x_neg ? -$signed({18'd0, dv_qa})
                                                      : $signed({18'd0, dv_qa}));
            q1_yn_reg <= ipm_pkg::sat32(dv_tail.y_neg ? -$signed({18'd0, dv_qb})
                                                      : $signed({18'd0, dv_qb}));
            q1_tail_reg <= dv_tail;

            q2_px_reg   <= q1_tail_reg.cal.fx * q1_xn_reg;
            q2_py_reg   <= q1_tail_reg.cal.fy * q1_yn_reg;
            q2_tail_reg <= q1_tail_reg;

            q3_px_reg   <= rnd_q32(65'(q2_px_reg) + (65'(q2_tail_reg.cal.cx) <<< 16));
            q3_py_reg   <= rnd_q32(65'(q2_py_reg) + (65'(q2_tail_reg.cal.cy) <<< 16));
            q3_tail_reg <= q2_tail_reg;

            out_beat_reg.cam_id <= q3_tail_reg.cal.cam;
            out_beat_reg.last   <= q3_tail_reg.cal.last;
            if (q3_tail_reg.behind)
            begin
                out_beat_reg.status <= ipm_pkg::ST_BEHIND;
                out_beat_reg.src_x  <= '0;
                out_beat_reg.src_y  <= '0;
            end
            else if (in_image)
            begin
                out_beat_reg.status <= ipm_pkg::ST_INSIDE;
                out_beat_reg.src_x  <= q3_px_reg[11:0];
                out_beat_reg.src_y  <= q3_py_reg[11:0];
            end
            else
            begin
                out_beat_reg.status <= ipm_pkg::ST_OUTSIDE;
                out_beat_reg.src_x  <= '0;
                out_beat_reg.src_y  <= '0;
            end
        end
    end

    ipm_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_n      (s5_sum_reg),
        .in_tail   (s5_tail_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tail  (sq_tail)
    );

    ipm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_a      (p2_a_reg),
        .in_b      (p2_b_reg),
        .in_d      (p2_d_reg),
        .in_tail   (p2_tail_reg),
        .out_valid (dv_valid),
        .out_qa    (dv_qa),
        .out_qb    (dv_qb),
        .out_tail  (dv_tail)
    );

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

`ifndef ASSERT_OFF
    a_last_cam: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_beat.last) |-> (out_beat.cam_id == 3'(NUM_CAMS - 1)))
        else $error("last flag on wrong camera");
    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_beat.status != ipm_pkg::ST_INSIDE))
        |-> (out_beat.src_x == 12'd0 && out_beat.src_y == 12'd0))
        else $error("coordinates set on a rejected pixel");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_beat.status == ipm_pkg::ST_INSIDE
                       || out_beat.status == ipm_pkg::ST_BEHIND
                       || out_beat.status == ipm_pkg::ST_OUTSIDE))
        else $error("bad status code");
`endif

endmodule

FILE: rtl/ipm_seq.sv
`timescale 1ns / 1ps

module ipm_seq #(
    parameter int NUM_CAMS = ipm_pkg::NUM_CAMS_DEF,
    parameter int BEV_SIZE = ipm_pkg::BEV_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    output logic               in_stall,
    input  ipm_pkg::in_beat_t  in_beat,
    input  logic               cfg_we,
    input  logic [20:0]        cfg_wdata,
    output logic               iss_valid,
    output ipm_pkg::issue_t    iss
);
    localparam int CW = (NUM_CAMS > 1) ? $clog2(NUM_CAMS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_CAMS - 1);

    logic [ipm_pkg::WORDS-1:0][31:0] calib_mem [NUM_CAMS];

    logic               busy_reg, busy_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [20:0]        scale_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic               iss_valid_reg;
    ipm_pkg::issue_t    iss_reg;

    logic               accept, issue, last_issue, is_map;
    logic signed [13:0] du, dv;
    logic signed [35:0] px, py;

    assign issue      = busy_reg && en;
    assign last_issue = issue && (cnt_reg == CNT_LAST);
    assign in_stall   = busy_reg && !last_issue;
    assign accept     = in_valid && !in_stall;
    assign is_map     = accept && (in_beat.op == ipm_pkg::OP_MAP);

    // ground point, exact then halved
    assign du = $signed({1'b0, in_beat.bev_u, 1'b0}) - 14'(BEV_SIZE);
    assign dv = 14'(BEV_SIZE) - $signed({1'b0, in_beat.bev_v, 1'b0});
    assign px = du * $signed({1'b0, scale_reg});
    assign py = dv * $signed({1'b0, scale_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (issue)
            cnt_next = cnt_reg + CW'(1);
        if (last_issue)
            busy_next = 1'b0;
        if (is_map)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            scale_reg     <= ipm_pkg::GS_RESET;
            iss_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (cfg_we)
                scale_reg <= cfg_wdata;
            if (en)
                iss_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_map)
        begin
            gx_reg <= ipm_pkg::sat32(66'(px >>> 1));
            gy_reg <= ipm_pkg::sat32(66'(py >>> 1));
        end
        if (accept && (in_beat.op == ipm_pkg::OP_LOAD) && (in_beat.cam_sel < NUM_CAMS)
            && (in_beat.coef_index < ipm_pkg::WORDS))
            calib_mem[in_beat.cam_sel[CW-1:0]][in_beat.coef_index] <= in_beat.coef_value;
        if (en)
        begin
            iss_reg.row  <= calib_mem[cnt_reg];
            iss_reg.cam  <= 3'(cnt_reg);
            iss_reg.last <= (cnt_reg == CNT_LAST);
            iss_reg.gx   <= gx_reg;
            iss_reg.gy   <= gy_reg;
        end
    end

    assign iss_valid = iss_valid_reg;
    assign iss       = iss_reg;

`ifndef ASSERT_OFF
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> busy_reg)
        else $error("stall without a pixel in progress");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CNT_LAST))
        else $error("camera counter out of range");
    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !in_stall)
        else $error("stall while idle");
`endif

endmodule

FILE: rtl/ipm_sqrt.sv
`timescale 1ns / 1ps

module ipm_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     in_n,
    input  ipm_pkg::tail_t  in_tail,
    output logic            out_valid,
    output logic [31:0]     out_root,
    output ipm_pkg::tail_t  out_tail
);
    localparam int STG = ipm_pkg::SQ_STG;

    logic           v_reg [STG];
    logic [63:0]    n_reg [STG];
    logic [34:0]    r_reg [STG];
    logic [31:0]    q_reg [STG];
    ipm_pkg::tail_t t_reg [STG];

    logic [63:0]    n_next [STG];
    logic [34:0]    r_next [STG];
    logic [31:0]    q_next [STG];

    // digit-by-digit root, two bits of the radicand per step
    always_comb
    begin
        logic [63:0] nn;
        logic [34:0] rr;
        logic [34:0] tt;
        logic [31:0] qq;
        for (int s = 0; s < STG; s++)
        begin
            if (s == 0)
            begin
                nn = in_n;
                rr = '0;
                qq = '0;
            end
            else
            begin
                nn = n_reg[s-1];
                rr = r_reg[s-1];
                qq = q_reg[s-1];
            end
            for (int k = 0; k < ipm_pkg::SQ_STEPS; k++)
            begin
                rr = {rr[32:0], nn[63:62]};
                tt = {1'b0, qq, 2'b01};
                if (rr >= tt)
                begin
                    rr = rr - tt;
                    qq = {qq[30:0], 1'b1};
                end
                else
                    qq = {qq[30:0], 1'b0};
                nn = {nn[61:0], 2'b00};
            end
            n_next[s] = nn;
            r_next[s] = rr;
            q_next[s] = qq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STG; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < STG; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= in_tail;
            for (int s = 0; s < STG; s++)
            begin
                n_reg[s] <= n_next[s];
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
                if (s > 0)
                    t_reg[s] <= t_reg[s-1];
            end
        end
    end

    assign out_valid = v_reg[STG-1];
    assign out_root  = q_reg[STG-1];
    assign out_tail  = t_reg[STG-1];

endmodule

FILE: rtl/ipm_div.sv
`timescale 1ns / 1ps

module ipm_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [47:0]         in_a,
    input  logic [47:0]         in_b,
    input  logic [30:0]         in_d,
    input  ipm_pkg::div_tail_t  in_tail,
    output logic                out_valid,
    output logic [47:0]         out_qa,
    output logic [47:0]         out_qb,
    output ipm_pkg::div_tail_t  out_tail
);
    localparam int STG = ipm_pkg::DV_STG;

    logic               v_reg  [STG];
    logic [47:0]        a_reg  [STG];
    logic [47:0]        b_reg  [STG];
    logic [31:0]        ra_reg [STG];
    logic [31:0]        rb_reg [STG];
    logic [30:0]        d_reg  [STG];
    ipm_pkg::div_tail_t t_reg  [STG];

    logic [47:0] a_next  [STG];
    logic [47:0] b_next  [STG];
    logic [31:0] ra_next [STG];
    logic [31:0] rb_next [STG];

    // restoring division on two lanes sharing one divisor;
    // quotient bits shift in behind the dividend
    always_comb
    begin
        logic [47:0] aa;
        logic [47:0] bb;
        logic [31:0] ra;
        logic [31:0] rb;
        logic [31:0] dd;
        for (int s = 0; s < STG; s++)
        begin
            if (s == 0)
            begin
                aa = in_a;
                bb = in_b;
                ra = '0;
                rb = '0;
                dd = {1'b0, in_d};
            end
            else
            begin
                aa = a_reg[s-1];
                bb = b_reg[s-1];
                ra = ra_reg[s-1];
                rb = rb_reg[s-1];
                dd = {1'b0, d_reg[s-1]};
            end
            for (int k = 0; k < ipm_pkg::DV_STEPS; k++)
            begin
                ra = {ra[30:0], aa[47]};
                rb = {rb[30:0], bb[47]};
                aa = {aa[46:0], 1'b0};
                bb = {bb[46:0], 1'b0};
                if (ra >= dd)
                begin
                    ra    = ra - dd;
                    aa[0] = 1'b1;
                end
                if (rb >= dd)
                begin
                    rb    = rb - dd;
                    bb[0] = 1'b1;
                end
            end
            a_next[s]  = aa;
            b_next[s]  = bb;
            ra_next[s] = ra;
            rb_next[s] = rb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STG; s++)
                v_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < STG; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= in_tail;
            d_reg[0] <= in_d;
            for (int s = 0; s < STG; s++)
            begin
                a_reg[s]  <= a_next[s];
                b_reg[s]  <= b_next[s];
                ra_reg[s] <= ra_next[s];
                rb_reg[s] <= rb_next[s];
                if (s > 0)
                begin
                    t_reg[s] <= t_reg[s-1];
                    d_reg[s] <= d_reg[s-1];
                end
            end
        end
    end

    assign out_valid = v_reg[STG-1];
    assign out_qa    = a_reg[STG-1];
    assign out_qb    = b_reg[STG-1];
    assign out_tail  = t_reg[STG-1];

endmodule
